[sv/salc_pkg.sv]
// ----------------------------------------------------------------------------
// salc_pkg
// Shared sizes, codes and types of the set-associative LRU cache model.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 64;

  localparam int ADDR_PORT_W  = 64;
  localparam int SET_W        = MAX_SET_BITS;
  localparam int WAY_W        = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LINE_W       = SET_W + WAY_W;
  localparam int SETS         = 1 << SET_W;
  localparam int LINES        = SETS << WAY_W;
  localparam int TAG_W        = 62;
  localparam int STAMP_W      = 32;
  localparam int CNT_W        = 32;
  localparam int MAX_BLOCK    = 16;

  localparam int SETB_W       = 3;
  localparam int WAYSU_W      = 4;
  localparam int BLKB_W       = 5;
  localparam int CFG_DATA_W   = 5;
  localparam int CFG_ADDR_W   = 2;
  localparam int CMD_W        = 2;

  localparam logic [ADDR_PORT_W-1:0] ADDR_MASK =
    {ADDR_PORT_W{1'b1}} >> (ADDR_PORT_W - ADDR_WIDTH);

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_WAYS_USED  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_BITS = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

endpackage

[sv/set_assoc_lru_cache_model_top.sv]
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_model_top
// Set-associative cache model with LRU replacement and saturating counters.
// ----------------------------------------------------------------------------
// One request returns one result. The ways of the indexed set are scanned one
// at a time through a single tag/stamp memory port, each read, then compared,
// stopping at a hit. A request that scans k ways (1..ways_used) passes ST_READ
// and ST_CMP per way, then ST_WRITE and ST_DONE, from acceptance to the next
// possible acceptance; the result is registered in ST_DONE, which a waiting
// result can hold. The result sits in an output register, so a new request is
// taken while it waits. After reset a clearing pass zeroes all 64 valid rows,
// one set per cycle; no request is taken meanwhile, configuration writes are.
module set_assoc_lru_cache_model_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [salc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [salc_pkg::CMD_W-1:0]           command_i,
  input  logic [salc_pkg::ADDR_PORT_W-1:0]     address_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 hit_o,
  output logic                                 eviction_o,
  output logic                                 extra_hit_o,
  output logic [salc_pkg::CNT_W-1:0]           hit_count_o,
  output logic [salc_pkg::CNT_W-1:0]           miss_count_o,
  output logic [salc_pkg::CNT_W-1:0]           eviction_count_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_DONE
  } state_e;

  localparam int SW = salc_pkg::SET_W;
  localparam int WW = salc_pkg::WAY_W;
  localparam int CW = salc_pkg::CNT_W;
  localparam int TW = salc_pkg::TAG_W;
  localparam int PW = salc_pkg::STAMP_W;
  localparam int NW = salc_pkg::MAX_WAYS;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    return (v == {CW{1'b1}}) ? v : v + 1'b1;
  endfunction

  state_e state_q;
  logic [SW-1:0] clr_q;

  logic [salc_pkg::SETB_W-1:0]  set_bits_q;
  logic [salc_pkg::WAYSU_W-1:0] ways_q;
  logic [salc_pkg::BLKB_W-1:0]  block_q;

  logic [PW-1:0] stamp_q;
  logic [CW-1:0] hits_q, misses_q, evicts_q;

  logic [SW-1:0] set_q;
  logic [TW-1:0] tag_q;
  logic          extra_q;
  logic [WW-1:0] w_q;
  logic          hit_q;
  logic          found_inv_q;
  logic [WW-1:0] inv_way_q;
  logic [PW-1:0] min_q;
  logic [WW-1:0] min_way_q;
  logic [NW-1:0] row_q;
  logic          evict_q;

  logic          out_valid_q, hit_oq, evict_oq, extra_oq;
  logic [CW-1:0] hit_cnt_oq, miss_cnt_oq, evict_cnt_oq;

  // memories
  salc_pkg::line_t line_mem [salc_pkg::LINES];
  logic [NW-1:0]   valid_mem [salc_pkg::SETS];
  salc_pkg::line_t ent_rd_q;
  logic [NW-1:0]   row_rd_q;

  // clamped configuration
  logic [salc_pkg::SETB_W-1:0]  s_c;
  logic [salc_pkg::WAYSU_W-1:0] e_c;
  logic [salc_pkg::BLKB_W-1:0]  b_c;

  always_comb begin
    if (set_bits_q == '0) begin
      s_c = salc_pkg::SETB_W'(1);
    end else if (set_bits_q > salc_pkg::SETB_W'(salc_pkg::MAX_SET_BITS)) begin
      s_c = salc_pkg::SETB_W'(salc_pkg::MAX_SET_BITS);
    end else begin
      s_c = set_bits_q;
    end
    if (ways_q == '0) begin
      e_c = salc_pkg::WAYSU_W'(1);
    end else if (ways_q > salc_pkg::WAYSU_W'(NW)) begin
      e_c = salc_pkg::WAYSU_W'(NW);
    end else begin
      e_c = ways_q;
    end
    if (block_q == '0) begin
      b_c = salc_pkg::BLKB_W'(1);
    end else if (block_q > salc_pkg::BLKB_W'(salc_pkg::MAX_BLOCK)) begin
      b_c = salc_pkg::BLKB_W'(salc_pkg::MAX_BLOCK);
    end else begin
      b_c = block_q;
    end
  end

  // address split
  logic [salc_pkg::ADDR_PORT_W-1:0] addr_m;
  logic [salc_pkg::ADDR_PORT_W-1:0] addr_set_sh, addr_tag_sh;
  logic [SW-1:0]                    set_mask, set_n;
  logic [TW-1:0]                    tag_n;
  logic [salc_pkg::BLKB_W:0]        tag_shift;

  always_comb begin
    addr_m      = address_i & salc_pkg::ADDR_MASK;
    tag_shift   = {3'b000, s_c} + {1'b0, b_c};
    addr_set_sh = addr_m >> b_c;
    addr_tag_sh = addr_m >> tag_shift;
    set_mask    = ~({SW{1'b1}} << s_c);
    set_n       = addr_set_sh[SW-1:0] & set_mask;
    tag_n       = addr_tag_sh[TW-1:0];
  end

  // scan compare unit
  logic          cur_vld, cur_match, cur_last, cur_less;
  logic [WW-1:0] wr_way;
  logic          evict_n;

  always_comb begin
    cur_vld   = row_rd_q[w_q];
    cur_match = cur_vld && (ent_rd_q.tag == tag_q);
    cur_last  = ({1'b0, w_q} == (e_c - 1'b1));
    cur_less  = (w_q == '0) || (ent_rd_q.stamp < min_q);
    wr_way    = hit_q ? w_q : (found_inv_q ? inv_way_q : min_way_q);
    evict_n   = !hit_q && !found_inv_q;
  end

  // counter update
  logic [CW-1:0] hits_a, hits_b;
  always_comb begin
    hits_a = hit_q ? sat_inc(hits_q) : hits_q;
    hits_b = extra_q ? sat_inc(hits_a) : hits_a;
  end

  logic in_acc;
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // memory ports
  logic          vmem_we;
  logic [SW-1:0] vmem_addr;
  logic [NW-1:0] vmem_wdata;
  logic [NW-1:0] way_bit;

  always_comb begin
    way_bit    = NW'(1) << wr_way;
    vmem_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
    vmem_addr  = (state_q == ST_CLEAR) ? clr_q : set_q;
    vmem_wdata = (state_q == ST_CLEAR) ? '0 : (row_q | way_bit);
  end

  always_ff @(posedge clk_i) begin
    if (vmem_we) begin
      valid_mem[vmem_addr] <= vmem_wdata;
    end
    row_rd_q <= valid_mem[set_q];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      line_mem[{set_q, wr_way}] <= '{tag: tag_q, stamp: stamp_q};
    end
    ent_rd_q <= line_mem[{set_q, w_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      set_bits_q   <= salc_pkg::SETB_W'(1);
      ways_q       <= salc_pkg::WAYSU_W'(1);
      block_q      <= salc_pkg::BLKB_W'(4);
      stamp_q      <= PW'(1);
      hits_q       <= '0;
      misses_q     <= '0;
      evicts_q     <= '0;
      out_valid_q  <= 1'b0;
      w_q          <= '0;
      hit_q        <= 1'b0;
      found_inv_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          salc_pkg::CFG_SET_BITS:   set_bits_q <= cfg_data_i[salc_pkg::SETB_W-1:0];
          salc_pkg::CFG_WAYS_USED:  ways_q     <= cfg_data_i[salc_pkg::WAYSU_W-1:0];
          salc_pkg::CFG_BLOCK_BITS: block_q    <= cfg_data_i[salc_pkg::BLKB_W-1:0];
          default: ;
        endcase
      end

      // in ST_DONE a taken result is replaced by the next one below
      if (out_valid_q && out_ready_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == {SW{1'b1}}) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            set_q       <= set_n;
            tag_q       <= tag_n;
            extra_q     <= (command_i == salc_pkg::CMD_MODIFY);
            stamp_q     <= stamp_q + 1'b1;
            w_q         <= '0;
            hit_q       <= 1'b0;
            found_inv_q <= 1'b0;
            state_q     <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_CMP;
        end
        ST_CMP: begin
          row_q <= row_rd_q;
          if (cur_match) begin
            hit_q   <= 1'b1;
            state_q <= ST_WRITE;
          end else begin
            if (!cur_vld && !found_inv_q) begin
              found_inv_q <= 1'b1;
              inv_way_q   <= w_q;
            end
            // oldest stamp among the valid ways ahead of the first free one
            if (cur_vld && !found_inv_q && cur_less) begin
              min_q     <= ent_rd_q.stamp;
              min_way_q <= w_q;
            end
            if (cur_last) begin
              state_q <= ST_WRITE;
            end else begin
              w_q     <= w_q + 1'b1;
              state_q <= ST_READ;
            end
          end
        end
        ST_WRITE: begin
          hits_q   <= hits_b;
          misses_q <= hit_q ? misses_q : sat_inc(misses_q);
          evicts_q <= evict_n ? sat_inc(evicts_q) : evicts_q;
          evict_q  <= evict_n;
          state_q  <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q  <= 1'b1;
            hit_oq       <= hit_q;
            evict_oq     <= evict_q;
            extra_oq     <= extra_q;
            hit_cnt_oq   <= hits_q;
            miss_cnt_oq  <= misses_q;
            evict_cnt_oq <= evicts_q;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = hit_oq;
  assign eviction_o       = evict_oq;
  assign extra_hit_o      = extra_oq;
  assign hit_count_o      = hit_cnt_oq;
  assign miss_count_o     = miss_cnt_oq;
  assign eviction_count_o = evict_cnt_oq;

endmodule

[sv/salc_checker.sv]
// ----------------------------------------------------------------------------
// salc_checker
// Port-level checks of the cache model, bound to the top level.
// ----------------------------------------------------------------------------
module salc_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             hit_o,
  input logic                             eviction_o,
  input logic                             extra_hit_o,
  input logic [salc_pkg::CNT_W-1:0]       hit_count_o,
  input logic [salc_pkg::CNT_W-1:0]       miss_count_o,
  input logic [salc_pkg::CNT_W-1:0]       eviction_count_o
);

  // a waiting result stays valid and keeps its counts
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(hit_count_o)
      && $stable(miss_count_o) && $stable(eviction_count_o))
    else $error("result changed while stalled");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while busy");

  a_evict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && eviction_o |-> !hit_o && (eviction_count_o != '0))
    else $error("eviction on a hit or with zero count");

  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((hit_o || extra_hit_o) ? (hit_count_o != '0) : 1'b1)
      && (hit_o ? 1'b1 : (miss_count_o != '0)))
    else $error("counter does not reflect result");

endmodule

bind set_assoc_lru_cache_model_top salc_checker u_salc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .hit_o            (hit_o),
  .eviction_o       (eviction_o),
  .extra_hit_o      (extra_hit_o),
  .hit_count_o      (hit_count_o),
  .miss_count_o     (miss_count_o),
  .eviction_count_o (eviction_count_o)
);
